### sv/m4inv_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and codes of the 4x4 matrix inverse
package m4inv_pkg;

   localparam int ELEM_W            = 32;
   localparam int POS_W             = 4;
   localparam int MAT_ELEMS         = 16;
   localparam int FRACTION_BITS_DEF = 16;
   // bank bit plus element position
   localparam int MAT_DEPTH         = 2 * MAT_ELEMS;
   localparam int MAT_AW            = $clog2(MAT_DEPTH);
   // signed cofactor and determinant widths, exact for any 32-bit input
   localparam int COF_W             = 98;
   localparam int DET_W             = 131;
   localparam int PROD_W            = 2 * (ELEM_W + 1);

   typedef enum logic [2:0] {
      OP_LOAD_A,
      OP_MUL_SET,
      OP_LOAD_B,
      OP_MUL_SUB,
      OP_MAC_LO,
      OP_MAC_HI
   } m4inv_op_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_COF,
      BK_FIX,
      BK_DET,
      BK_DPREP,
      BK_DRD,
      BK_DNUM,
      BK_DCHK,
      BK_DITER,
      BK_DFIN,
      BK_EMIT
   } m4inv_bstate_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } m4inv_head_type;

   typedef struct packed {
      logic pop;
      logic release_bank;
   } m4inv_back_ctl_type;

endpackage

### sv/m4inv_ram.sv
`timescale 1ns / 1ps
// generic single write port ram with registered read
module m4inv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/m4inv_fifo.sv
`timescale 1ns / 1ps
// two entry queue of loaded matrix banks
module m4inv_fifo import m4inv_pkg::*; #(
   parameter int WIDTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] head
);

   logic [WIDTH-1:0] data_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign not_empty = count_ff != 2'd0;
   assign head      = data_ff[rd_ptr_ff];

endmodule

### sv/m4inv_front.sv
`timescale 1ns / 1ps
// request side: writes elements into a free bank and queues full matrices
module m4inv_front import m4inv_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [ELEM_W-1:0]    req_element_value,
   output logic                 wr_en,
   output logic [MAT_AW-1:0]    wr_addr,
   output logic [ELEM_W-1:0]    wr_data,
   output logic                 push,
   output logic                 push_bank,
   input  m4inv_back_ctl_type   back_ctl
);

   logic [POS_W-1:0] count_ff, count_in;
   logic             bank_ff, bank_in;
   logic [1:0]       held_ff, held_in;
   logic             accept;

   assign req_stall = held_ff == 2'd2;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      count_in  = count_ff;
      bank_in   = bank_ff;
      push      = 1'b0;
      if (accept) begin
         count_in = count_ff + 1'b1;
         if (count_ff == POS_W'(MAT_ELEMS - 1)) begin
            push    = 1'b1;
            bank_in = ~bank_ff;
         end
      end
      held_in = held_ff + 2'(push) - 2'(back_ctl.release_bank);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         bank_ff  <= 1'b0;
         held_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         bank_ff  <= bank_in;
         held_ff  <= held_in;
      end
   end

   assign wr_en     = accept;
   assign wr_addr   = {bank_ff, count_ff};
   assign wr_data   = req_element_value;
   assign push_bank = bank_ff;

endmodule

### sv/m4inv_back.sv
`timescale 1ns / 1ps
// cofactor and determinant engine, restoring divider and result register
module m4inv_back import m4inv_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  m4inv_head_type           head,
   output m4inv_back_ctl_type       ctl,
   output logic [MAT_AW-1:0]        mat_rd_addr,
   input  logic [ELEM_W-1:0]        mat_rd_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [ELEM_W-1:0] rsp_inverse_value,
   output logic [POS_W-1:0]         rsp_element_position,
   output logic                     rsp_is_singular,
   output logic                     rsp_saturated,
   output logic                     rsp_last_of_run
);

   localparam int NUM_W = COF_W + 2 * FRACTION_BITS;
   localparam int HI_W  = NUM_W - ELEM_W;

   function automatic logic [1:0] skip_idx(input logic [1:0] k, input logic [1:0] drop);
      return (k < drop) ? k : k + 2'd1;
   endfunction

   m4inv_bstate_type state_ff, state_in;
   m4inv_op_type     op_ff, op_in;
   logic             bank_ff, bank_in;
   logic [1:0]       ridx_ff, ridx_in, cidx_ff, cidx_in;
   logic [1:0]       term_ff, term_in, ph_ff, ph_in, limb_ff, limb_in;
   logic signed [ELEM_W-1:0] opa_ff, opa_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ELEM_W:0]   mul_a, mul_b;
   logic [2*ELEM_W-1:0]      minor_ff, minor_in;
   logic signed [COF_W-1:0]  acc_ff, acc_in, cof_ff, cof_in, cof_rd, prod_c;
   logic signed [DET_W-1:0]  det_ff, det_in;
   logic [DET_W-1:0]         dabs_ff, dabs_in, rem_ff, rem_in, rem2;
   logic                     dneg_ff, dneg_in, sing_ff, sing_in, nneg_ff, nneg_in;
   logic [COF_W-1:0]         cmag, cof_rd_raw;
   logic [NUM_W-1:0]         num_ff, num_in;
   logic [HI_W-1:0]          num_hi;
   logic [ELEM_W-1:0]        q_ff, q_in, res_ff, res_in;
   logic                     rsat_ff, rsat_in, qneg;
   logic [4:0]               bit_ff, bit_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic [1:0]               ca, cb, mk, mj, mrow, mcol;
   logic                     cof_wr_en, out_free;
   logic [POS_W-1:0]         cof_addr;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [ELEM_W-1:0] out_val_ff, out_val_in;
   logic [POS_W-1:0]         out_pos_ff, out_pos_in;
   logic                     out_sing_ff, out_sing_in, out_sat_ff, out_sat_in;
   logic                     out_last_ff, out_last_in;

   m4inv_ram #(
      .WIDTH (COF_W),
      .DEPTH (MAT_ELEMS)
   ) u_cof_ram (
      .clock   (clock),
      .wr_en   (cof_wr_en),
      .wr_addr ({ridx_ff, cidx_ff}),
      .wr_data (cof_in),
      .rd_addr (cof_addr),
      .rd_data (cof_rd_raw)
   );

   assign cof_rd   = signed'(cof_rd_raw);
   assign cof_addr = pos_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign num_hi   = num_ff[NUM_W-1:ELEM_W];
   assign qneg     = nneg_ff ^ dneg_ff;

   // operand addressing of the 3x3 minor
   always_comb begin
      ca = (term_ff == 2'd0) ? 2'd1 : 2'd0;
      cb = (term_ff == 2'd2) ? 2'd1 : 2'd2;
      case (op_ff)
         OP_LOAD_A:  begin mk = 2'd1; mj = ca; end
         OP_MUL_SET: begin mk = 2'd2; mj = cb; end
         OP_LOAD_B:  begin mk = 2'd1; mj = cb; end
         OP_MUL_SUB: begin mk = 2'd2; mj = ca; end
         default:    begin mk = 2'd0; mj = term_ff; end
      endcase
      mrow = skip_idx(mk, ridx_ff);
      mcol = skip_idx(mj, cidx_ff);
      mat_rd_addr = (state_ff == BK_DET) ? {bank_ff, cidx_ff, 2'b00}
                                         : {bank_ff, mcol, mrow};
   end

   // shared multiplier
   always_comb begin
      mul_b = signed'({mat_rd_data[ELEM_W-1], mat_rd_data});
      if (state_ff == BK_DET) begin
         case (limb_ff)
            2'd0:    mul_a = signed'({1'b0, cof_ff[ELEM_W-1:0]});
            2'd1:    mul_a = signed'({1'b0, cof_ff[2*ELEM_W-1:ELEM_W]});
            2'd2:    mul_a = signed'({1'b0, cof_ff[3*ELEM_W-1:2*ELEM_W]});
            default: mul_a = signed'({{(ELEM_W+1-(COF_W-3*ELEM_W)){cof_ff[COF_W-1]}},
                                      cof_ff[COF_W-1:3*ELEM_W]});
         endcase
      end else begin
         case (op_ff)
            OP_MAC_LO: mul_a = signed'({1'b0, minor_ff[ELEM_W-1:0]});
            OP_MAC_HI: mul_a = signed'({minor_ff[2*ELEM_W-1], minor_ff[2*ELEM_W-1:ELEM_W]});
            default:   mul_a = signed'({opa_ff[ELEM_W-1], opa_ff});
         endcase
      end
      prod_in = mul_a * mul_b;
      prod_c  = COF_W'(prod_ff);
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      bank_in      = bank_ff;
      ridx_in      = ridx_ff;
      cidx_in      = cidx_ff;
      term_in      = term_ff;
      ph_in        = ph_ff;
      limb_in      = limb_ff;
      opa_in       = opa_ff;
      minor_in     = minor_ff;
      acc_in       = acc_ff;
      cof_in       = (ridx_ff[0] ^ cidx_ff[0]) ? -acc_ff : acc_ff;
      det_in       = det_ff;
      dabs_in      = dabs_ff;
      dneg_in      = dneg_ff;
      sing_in      = sing_ff;
      nneg_in      = nneg_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      res_in       = res_ff;
      rsat_in      = rsat_ff;
      bit_in       = bit_ff;
      pos_in       = pos_ff;
      cof_wr_en    = 1'b0;
      ctl.pop          = 1'b0;
      ctl.release_bank = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_val_in   = out_val_ff;
      out_pos_in   = out_pos_ff;
      out_sing_in  = out_sing_ff;
      out_sat_in   = out_sat_ff;
      out_last_in  = out_last_ff;
      cmag         = cof_rd[COF_W-1] ? COF_W'(-cof_rd) : cof_rd;
      rem2         = {rem_ff[DET_W-2:0], num_ff[bit_ff]};
      case (state_ff)
         BK_IDLE: begin
            if (head.valid) begin
               ctl.pop  = 1'b1;
               bank_in  = head.bank;
               ridx_in  = 2'd0;
               cidx_in  = 2'd0;
               term_in  = 2'd0;
               op_in    = OP_LOAD_A;
               ph_in    = 2'd0;
               acc_in   = '0;
               det_in   = '0;
               state_in = BK_COF;
            end
         end
         BK_COF: begin
            ph_in = ph_ff + 2'd1;
            if (ph_ff == 2'd1 && (op_ff == OP_LOAD_A || op_ff == OP_LOAD_B)) begin
               opa_in = signed'(mat_rd_data);
            end
            if (ph_ff == 2'd2) begin
               ph_in = 2'd0;
               case (op_ff)
                  OP_MUL_SET: minor_in = prod_ff[2*ELEM_W-1:0];
                  OP_MUL_SUB: minor_in = minor_ff - prod_ff[2*ELEM_W-1:0];
                  OP_MAC_LO:  acc_in = (term_ff == 2'd1) ? acc_ff - prod_c : acc_ff + prod_c;
                  OP_MAC_HI:  acc_in = (term_ff == 2'd1) ? acc_ff - (prod_c <<< ELEM_W)
                                                         : acc_ff + (prod_c <<< ELEM_W);
                  default:    minor_in = minor_ff;
               endcase
               if (op_ff == OP_MAC_HI) begin
                  op_in = OP_LOAD_A;
                  if (term_ff == 2'd2) begin
                     state_in = BK_FIX;
                  end else begin
                     term_in = term_ff + 2'd1;
                  end
               end else begin
                  op_in = m4inv_op_type'(op_ff + 3'd1);
               end
            end
         end
         BK_FIX: begin
            cof_wr_en = 1'b1;
            term_in   = 2'd0;
            acc_in    = '0;
            ph_in     = 2'd0;
            limb_in   = 2'd0;
            {ridx_in, cidx_in} = {ridx_ff, cidx_ff} + 4'd1;
            if (ridx_ff == 2'd0) begin
               cidx_in  = cidx_ff;
               state_in = BK_DET;
            end else if ({ridx_ff, cidx_ff} == 4'hF) begin
               state_in = BK_DPREP;
            end else begin
               state_in = BK_COF;
            end
         end
         BK_DET: begin
            ph_in = ph_ff + 2'd1;
            if (ph_ff == 2'd2) begin
               ph_in   = 2'd0;
               det_in  = det_ff + (DET_W'(prod_ff) <<< (ELEM_W * limb_ff));
               limb_in = limb_ff + 2'd1;
               if (limb_ff == 2'd3) begin
                  cidx_in  = cidx_ff + 2'd1;
                  ridx_in  = (cidx_ff == 2'd3) ? 2'd1 : 2'd0;
                  state_in = BK_COF;
               end
            end
         end
         BK_DPREP: begin
            ctl.release_bank = 1'b1;
            dneg_in  = det_ff[DET_W-1];
            dabs_in  = det_ff[DET_W-1] ? DET_W'(-det_ff) : det_ff;
            sing_in  = det_ff == '0;
            pos_in   = '0;
            state_in = BK_DRD;
         end
         BK_DRD: begin
            state_in = BK_DNUM;
         end
         BK_DNUM: begin
            nneg_in = cof_rd[COF_W-1];
            num_in  = NUM_W'(cmag) << (2 * FRACTION_BITS);
            if (sing_ff) begin
               res_in   = '0;
               rsat_in  = 1'b0;
               state_in = BK_EMIT;
            end else begin
               state_in = BK_DCHK;
            end
         end
         BK_DCHK: begin
            if (DET_W'(num_hi) >= dabs_ff) begin
               rsat_in  = 1'b1;
               res_in   = qneg ? {1'b1, {(ELEM_W-1){1'b0}}} : {1'b0, {(ELEM_W-1){1'b1}}};
               state_in = BK_EMIT;
            end else begin
               rem_in   = DET_W'(num_hi);
               q_in     = '0;
               bit_in   = 5'(ELEM_W - 1);
               state_in = BK_DITER;
            end
         end
         BK_DITER: begin
            rem_in = (rem2 >= dabs_ff) ? rem2 - dabs_ff : rem2;
            q_in   = {q_ff[ELEM_W-2:0], rem2 >= dabs_ff};
            bit_in = bit_ff - 5'd1;
            if (bit_ff == 5'd0) begin
               state_in = BK_DFIN;
            end
         end
         BK_DFIN: begin
            rsat_in = 1'b0;
            if (qneg) begin
               if (q_ff > {1'b1, {(ELEM_W-1){1'b0}}}) begin
                  rsat_in = 1'b1;
                  res_in  = {1'b1, {(ELEM_W-1){1'b0}}};
               end else begin
                  res_in  = -q_ff;
               end
            end else if (q_ff[ELEM_W-1]) begin
               rsat_in = 1'b1;
               res_in  = {1'b0, {(ELEM_W-1){1'b1}}};
            end else begin
               res_in  = q_ff;
            end
            state_in = BK_EMIT;
         end
         BK_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_val_in   = signed'(res_ff);
               out_pos_in   = pos_ff;
               out_sing_in  = sing_ff;
               out_sat_in   = rsat_ff;
               out_last_in  = pos_ff == POS_W'(MAT_ELEMS - 1);
               pos_in       = pos_ff + 1'b1;
               state_in     = (pos_ff == POS_W'(MAT_ELEMS - 1)) ? BK_IDLE : BK_DRD;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      bank_ff     <= bank_in;
      ridx_ff     <= ridx_in;
      cidx_ff     <= cidx_in;
      term_ff     <= term_in;
      ph_ff       <= ph_in;
      limb_ff     <= limb_in;
      opa_ff      <= opa_in;
      prod_ff     <= prod_in;
      minor_ff    <= minor_in;
      acc_ff      <= acc_in;
      cof_ff      <= (state_ff == BK_FIX) ? cof_in : cof_ff;
      det_ff      <= det_in;
      dabs_ff     <= dabs_in;
      dneg_ff     <= dneg_in;
      sing_ff     <= sing_in;
      nneg_ff     <= nneg_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      q_ff        <= q_in;
      res_ff      <= res_in;
      rsat_ff     <= rsat_in;
      bit_ff      <= bit_in;
      pos_ff      <= pos_in;
      out_val_ff  <= out_val_in;
      out_pos_ff  <= out_pos_in;
      out_sing_ff <= out_sing_in;
      out_sat_ff  <= out_sat_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_inverse_value    = out_val_ff;
   assign rsp_element_position = out_pos_ff;
   assign rsp_is_singular      = out_sing_ff;
   assign rsp_saturated        = out_sat_ff;
   assign rsp_last_of_run      = out_last_ff;

endmodule

### sv/matrix_4x4_inverse_top.sv
`timescale 1ns / 1ps
// top level of the fixed-point 4x4 matrix inverse
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   request | req_valid req_stall req_element_value   | in
//   result  | rsp_valid rsp_stall rsp_inverse_value    | out
//           | rsp_element_position rsp_is_singular     |
//           | rsp_saturated rsp_last_of_run            |
//
// elements load at one per cycle into one of two banks; a third matrix
// stalls until the engine has released a bank
// per matrix the engine forms 16 cofactors on one shared 33x33 multiplier,
// adding each first-row cofactor into the determinant on the same multiplier,
// then runs the one-bit-a-cycle divider once for each result element
// reset is synchronous and clears control only; no clearing pass
// a stalled result holds the divider, not the request side
module matrix_4x4_inverse_top import m4inv_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [ELEM_W-1:0] req_element_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [ELEM_W-1:0] rsp_inverse_value,
   output logic [POS_W-1:0]         rsp_element_position,
   output logic                     rsp_is_singular,
   output logic                     rsp_saturated,
   output logic                     rsp_last_of_run
);

   logic               wr_en, push, push_bank;
   logic [MAT_AW-1:0]  wr_addr, rd_addr;
   logic [ELEM_W-1:0]  wr_data, rd_data;
   m4inv_head_type     head;
   m4inv_back_ctl_type back_ctl;

   m4inv_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_element_value (req_element_value),
      .wr_en             (wr_en),
      .wr_addr           (wr_addr),
      .wr_data           (wr_data),
      .push              (push),
      .push_bank         (push_bank),
      .back_ctl          (back_ctl)
   );

   m4inv_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (MAT_DEPTH)
   ) u_mat_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   m4inv_fifo #(
      .WIDTH (1)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_bank),
      .pop       (back_ctl.pop),
      .not_empty (head.valid),
      .head      (head.bank)
   );

   m4inv_back #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .head                 (head),
      .ctl                  (back_ctl),
      .mat_rd_addr          (rd_addr),
      .mat_rd_data          (rd_data),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_inverse_value    (rsp_inverse_value),
      .rsp_element_position (rsp_element_position),
      .rsp_is_singular      (rsp_is_singular),
      .rsp_saturated        (rsp_saturated),
      .rsp_last_of_run      (rsp_last_of_run)
   );

endmodule

### verif/matrix_4x4_inverse_top_tb.sv
`timescale 1ns / 1ps
// testbench of the 4x4 matrix inverse: random and corner matrices, checked by exact predictor
module matrix_4x4_inverse_top_tb import m4inv_pkg::*;;

   typedef struct {
      logic signed [ELEM_W-1:0] value;
      bit                       drain;
   } elem_request_type;

   typedef struct {
      logic signed [ELEM_W-1:0] inverse_value;
      logic [POS_W-1:0]         position;
      logic                     singular;
      logic                     saturated;
      logic                     last;
   } inverse_result_type;

   localparam int F_BITS     = FRACTION_BITS_DEF;
   localparam int STALL_LIMIT = 20000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic signed [ELEM_W-1:0] req_element_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [ELEM_W-1:0] rsp_inverse_value;
   logic [POS_W-1:0]         rsp_element_position;
   logic                     rsp_is_singular;
   logic                     rsp_saturated;
   logic                     rsp_last_of_run;

   elem_request_type   pending_elems[$];
   inverse_result_type expected_inverse[$];
   logic signed [ELEM_W-1:0] shadow_matrix[MAT_ELEMS];
   int  shadow_count = 0;
   int  error_count = 0;
   int  results_seen = 0;
   int  matrices_sent = 0;
   int  singular_seen = 0;
   int  saturated_seen = 0;
   int  send_gap = 0;
   int  recv_gap = 0;
   int  hold_count = 0;
   bit  hold_done = 0;
   int  idle_cycles = 0;

   always #5 clock = ~clock;

   matrix_4x4_inverse_top dut (.*);

   function automatic logic signed [191:0] elem_at(int r, int c);
      logic signed [191:0] v;
      v = shadow_matrix[c * 4 + r];
      return v;
   endfunction

   function automatic logic signed [191:0] minor_cofactor(int r, int c);
      int rr[3], cc[3];
      int k, j;
      logic signed [191:0] m[3][3];
      logic signed [191:0] t;
      k = 0;
      j = 0;
      for (int i = 0; i < 4; i++) begin
         if (i != r) begin
            rr[k] = i;
            k++;
         end
         if (i != c) begin
            cc[j] = i;
            j++;
         end
      end
      for (int a = 0; a < 3; a++)
         for (int b = 0; b < 3; b++)
            m[a][b] = elem_at(rr[a], cc[b]);
      t = m[0][0] * (m[1][1] * m[2][2] - m[1][2] * m[2][1])
        - m[0][1] * (m[1][0] * m[2][2] - m[1][2] * m[2][0])
        + m[0][2] * (m[1][0] * m[2][1] - m[1][1] * m[2][0]);
      return ((r + c) % 2 == 1) ? -t : t;
   endfunction

   // store one element; the sixteenth yields the whole inverse
   function automatic void load_element(logic signed [ELEM_W-1:0] value);
      logic signed [191:0] cof[4][4];
      logic signed [191:0] det, num, quo;
      inverse_result_type res;
      shadow_matrix[shadow_count] = value;
      shadow_count = (shadow_count + 1) % MAT_ELEMS;
      if (shadow_count != 0) return;
      det = '0;
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++)
            cof[r][c] = minor_cofactor(r, c);
      for (int c = 0; c < 4; c++)
         det = det + cof[0][c] * elem_at(0, c);
      for (int p = 0; p < MAT_ELEMS; p++) begin
         res.position = POS_W'(p);
         res.last = (p == MAT_ELEMS - 1);
         res.singular = (det == 0);
         res.saturated = 1'b0;
         res.inverse_value = '0;
         if (det != 0) begin
            num = cof[p / 4][p % 4] <<< (2 * F_BITS);
            quo = num / det;
            if (quo > 192'sd2147483647) begin
               res.inverse_value = 32'h7fffffff;
               res.saturated = 1'b1;
            end else if (quo < -192'sd2147483648) begin
               res.inverse_value = 32'h80000000;
               res.saturated = 1'b1;
            end else begin
               res.inverse_value = quo[ELEM_W-1:0];
            end
         end
         expected_inverse.push_back(res);
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_element_value <= '0;
         send_gap <= 0;
      end else begin
         if (req_valid && !req_stall)
            load_element(req_element_value);
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_elems.size() == 0 ||
                         (pending_elems[0].drain && expected_inverse.size() > 0)) begin
               req_valid <= 1'b0;
            end else if (pending_elems.size() > 32 && $urandom_range(0, 9) == 0) begin
               send_gap <= $urandom_range(0, 7);
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_element_value <= pending_elems.pop_front().value;
            end
         end
      end
   end

   // result monitor and receiver stall
   always @(posedge clock) begin
      inverse_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_inverse.size() == 0) begin
               $display("%0t: unexpected result pos %0d value %h", $time,
                        rsp_element_position, rsp_inverse_value);
               error_count++;
            end else begin
               want = expected_inverse.pop_front();
               if (want.singular) singular_seen++;
               if (want.saturated) saturated_seen++;
               if (rsp_inverse_value !== want.inverse_value) begin
                  $display("%0t: inverse_value expected %h actual %h", $time,
                           want.inverse_value, rsp_inverse_value);
                  error_count++;
               end
               if (rsp_element_position !== want.position) begin
                  $display("%0t: element_position expected %0d actual %0d", $time,
                           want.position, rsp_element_position);
                  error_count++;
               end
               if (rsp_is_singular !== want.singular) begin
                  $display("%0t: is_singular expected %b actual %b", $time,
                           want.singular, rsp_is_singular);
                  error_count++;
               end
               if (rsp_saturated !== want.saturated) begin
                  $display("%0t: saturated expected %b actual %b", $time,
                           want.saturated, rsp_saturated);
                  error_count++;
               end
               if (rsp_last_of_run !== want.last) begin
                  $display("%0t: last_of_run expected %b actual %b", $time,
                           want.last, rsp_last_of_run);
                  error_count++;
               end
            end
         end
         if (!hold_done && results_seen >= 40) begin
            hold_done <= 1;
            hold_count <= 3000;
            rsp_stall <= 1'b1;
         end else if (hold_count > 0) begin
            hold_count <= hold_count - 1;
            rsp_stall <= (hold_count > 1);
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_stall <= (recv_gap > 1);
         end else if (results_seen < 140 && $urandom_range(0, 7) == 0) begin
            recv_gap <= $urandom_range(1, 8);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: timeout, nothing accepted for %0d cycles", $time, idle_cycles);
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic queue_matrix(input int kind, input bit drain);
      elem_request_type e;
      for (int i = 0; i < MAT_ELEMS; i++) begin
         e.drain = drain && (i == 0);
         case (kind)
            0: e.value = $urandom;
            1: e.value = $signed($urandom_range(0, 2 ** 19)) - 32'sd262144;
            default: e.value = (i % 5 == 0) ?
                        32'sd1048576 + $signed($urandom_range(0, 2 ** 20))
                      : $signed($urandom_range(0, 2 ** 17)) - 32'sd65536;
         endcase
         pending_elems.push_back(e);
      end
      matrices_sent++;
   endtask

   initial begin
      elem_request_type e;
      e.drain = 0;
      // tiny diagonal with extremes: saturates both ways
      for (int i = 0; i < MAT_ELEMS; i++) begin
         case (i)
            0:  e.value = 32'sd1;
            5:  e.value = -32'sd1;
            10: e.value = 32'h7fffffff;
            15: e.value = 32'h80000000;
            default: e.value = '0;
         endcase
         pending_elems.push_back(e);
      end
      // all zero: singular
      for (int i = 0; i < MAT_ELEMS; i++) begin
         e.value = '0;
         pending_elems.push_back(e);
      end
      // identity scaled to one
      for (int i = 0; i < MAT_ELEMS; i++) begin
         e.value = (i % 5 == 0) ? 32'sd65536 : 32'sd0;
         pending_elems.push_back(e);
      end
      matrices_sent = 3;
      for (int m = 0; m < 8; m++)
         queue_matrix(m % 3, m == 4);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait (pending_elems.size() == 0 && !req_valid);
      wait (expected_inverse.size() == 0);
      repeat (2000) begin
         @(posedge clock);
         if (expected_inverse.size() > 0) error_count = error_count;
      end
      if (expected_inverse.size() > 0) begin
         $display("%0t: %0d expected results never arrived", $time, expected_inverse.size());
         error_count++;
      end
      $display("covered %0d matrices, %0d results, %0d singular, %0d saturated",
               matrices_sent, results_seen, singular_seen, saturated_seen);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

### filelist.f
sv/m4inv_pkg.sv
sv/m4inv_ram.sv
sv/m4inv_fifo.sv
sv/m4inv_front.sv
sv/m4inv_back.sv
sv/matrix_4x4_inverse_top.sv
verif/matrix_4x4_inverse_top_tb.sv
